// ----- rtl/core/dbm_pkg.sv -----
// Package for the driving-mode state machine.
// Holds the mode codes, the hold-threshold register set and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbm_pkg;

    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned ELAPSED_W = 10;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_CRUISE  = 3'd0,
        MODE_FOLLOW  = 3'd1,
        MODE_PREPARE = 3'd2,
        MODE_EXECUTE = 3'd3,
        MODE_BRAKE   = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOLLOW_TO_PREPARE = 2'd0,
        REG_PREPARE_ABORT     = 2'd1,
        REG_EXECUTE_DONE      = 2'd2,
        REG_BRAKE_RELEASE     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [HOLD_W-1:0] follow_to_prepare_hold;
        logic [HOLD_W-1:0] prepare_abort_hold;
        logic [HOLD_W-1:0] execute_done_hold;
        logic [HOLD_W-1:0] brake_release_hold;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [HOLD_W-1:0] hold;
    } step_t;

    localparam logic [HOLD_W-1:0] FOLLOW_TO_PREPARE_RST = 16'd300;
    localparam logic [HOLD_W-1:0] PREPARE_ABORT_RST     = 16'd500;
    localparam logic [HOLD_W-1:0] EXECUTE_DONE_RST      = 16'd800;
    localparam logic [HOLD_W-1:0] BRAKE_RELEASE_RST     = 16'd500;

endpackage

`default_nettype wire

// ----- rtl/core/dbm_cfg_regs.sv -----
// Hold-threshold register file, written through a plain write port.
// Depends on dbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbm_cfg_regs
    import dbm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HOLD_W-1:0]    cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.follow_to_prepare_hold <= FOLLOW_TO_PREPARE_RST;
            cfg_reg.prepare_abort_hold     <= PREPARE_ABORT_RST;
            cfg_reg.execute_done_hold      <= EXECUTE_DONE_RST;
            cfg_reg.brake_release_hold     <= BRAKE_RELEASE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_FOLLOW_TO_PREPARE: cfg_reg.follow_to_prepare_hold <= cfg_wdata;
                REG_PREPARE_ABORT:     cfg_reg.prepare_abort_hold     <= cfg_wdata;
                REG_EXECUTE_DONE:      cfg_reg.execute_done_hold      <= cfg_wdata;
                REG_BRAKE_RELEASE:     cfg_reg.brake_release_hold     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dbm_next_mode.sv -----
// Next-mode logic: saturating hold timer update and mode transitions.
// Purely combinational. Depends on dbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbm_next_mode
    import dbm_pkg::*;
(
    input  wire mode_t             mode,
    input  wire logic [HOLD_W-1:0] hold,
    input  wire cfg_t              cfg,
    input  wire logic              emergency,
    input  wire logic              slow_vehicle_ahead,
    input  wire logic              change_wanted,
    input  wire logic              change_active,
    input  wire logic [ELAPSED_W-1:0] elapsed_ms,
    output step_t                  step
);

    logic [HOLD_W:0]   hold_sum;
    logic [HOLD_W-1:0] hold_sat;
    logic              enter;
    mode_t             target;

    always_comb begin
        hold_sum = {1'b0, hold} + {{(HOLD_W + 1 - ELAPSED_W){1'b0}}, elapsed_ms};
        hold_sat = hold_sum[HOLD_W] ? HOLD_MAX : hold_sum[HOLD_W-1:0];
    end

    always_comb begin
        enter  = 1'b0;
        target = mode;
        if (emergency) begin
            // brake re-entered from brake still clears the timer
            enter  = 1'b1;
            target = MODE_BRAKE;
        end else begin
            case (mode)
                MODE_FOLLOW: begin
                    if (!slow_vehicle_ahead) begin
                        enter  = 1'b1;
                        target = MODE_CRUISE;
                    end else if (change_wanted && hold_sat > cfg.follow_to_prepare_hold) begin
                        enter  = 1'b1;
                        target = MODE_PREPARE;
                    end
                end
                MODE_PREPARE: begin
                    if (change_active) begin
                        enter  = 1'b1;
                        target = MODE_EXECUTE;
                    end else if (!change_wanted && hold_sat > cfg.prepare_abort_hold) begin
                        enter  = 1'b1;
                        target = slow_vehicle_ahead ? MODE_FOLLOW : MODE_CRUISE;
                    end
                end
                MODE_EXECUTE: begin
                    if (!change_active && hold_sat > cfg.execute_done_hold) begin
                        enter  = 1'b1;
                        target = MODE_CRUISE;
                    end
                end
                MODE_BRAKE: begin
                    if (!slow_vehicle_ahead && hold_sat > cfg.brake_release_hold) begin
                        enter  = 1'b1;
                        target = MODE_CRUISE;
                    end
                end
                default: begin
                    // cruise, and any stray code behaves like cruise
                    if (slow_vehicle_ahead && change_wanted) begin
                        enter  = 1'b1;
                        target = MODE_PREPARE;
                    end else if (slow_vehicle_ahead) begin
                        enter  = 1'b1;
                        target = MODE_FOLLOW;
                    end
                end
            endcase
        end
    end

    always_comb begin
        step.mode = target;
        step.hold = enter ? '0 : hold_sat;
    end

endmodule

`default_nettype wire

// ----- rtl/core/driving_behavior_mode_fsm.sv -----
// Channel   | Ports                                            | Direction
// ----------+--------------------------------------------------+----------
// input     | s_valid s_ready s_emergency s_slow_vehicle_ahead |  in
//           | s_change_wanted s_change_active s_elapsed_ms     |
// result    | m_valid m_ready m_mode_now                       |  out
// config    | cfg_wr_en cfg_index cfg_wdata                    |  in
//
// One item per cycle; its result appears in m_mode_now the cycle after acceptance.
// The mode and hold timer update combinationally from their registers, so items may
// follow back to back. s_ready is low only while a result is held and m_ready is low.
// Synchronous active-low reset: cruise, timer zero, thresholds to defaults.
// Depends on dbm_pkg, dbm_cfg_regs and dbm_next_mode.
`timescale 1ns / 1ps
`default_nettype none

module driving_behavior_mode_fsm
    import dbm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_emergency,
    input  wire logic                 s_slow_vehicle_ahead,
    input  wire logic                 s_change_wanted,
    input  wire logic                 s_change_active,
    input  wire logic [ELAPSED_W-1:0] s_elapsed_ms,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [MODE_W-1:0]         m_mode_now,

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HOLD_W-1:0]    cfg_wdata
);

    cfg_t              cfg;
    step_t             step;
    mode_t             mode_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic              m_valid_reg;
    logic              accept;

    dbm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dbm_next_mode u_next (
        .mode               (mode_reg),
        .hold               (hold_reg),
        .cfg                (cfg),
        .emergency          (s_emergency),
        .slow_vehicle_ahead (s_slow_vehicle_ahead),
        .change_wanted      (s_change_wanted),
        .change_active      (s_change_active),
        .elapsed_ms         (s_elapsed_ms),
        .step               (step)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_CRUISE;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg <= step.mode;
                hold_reg <= step.hold;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // the mode register doubles as the result payload
    assign m_valid    = m_valid_reg;
    assign m_mode_now = mode_reg;

endmodule

`default_nettype wire
